FILE: sv/esp_pkg.sv
package esp_pkg;

    localparam int PATTERN_SLOTS = 3;

    // Configuration register map.
    localparam int CFG_REGS      = 3 + PATTERN_SLOTS;
    localparam int CFG_IDX_W     = $clog2(CFG_REGS);
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_MODE      = 0;
    localparam int CFG_COOLANT   = 1;
    localparam int CFG_PEDAL     = 2;
    localparam int CFG_SLOT_BASE = 3;

    // Cut mode codes; any other code covers both event types.
    localparam logic [1:0] CUT_SPARK = 2'd0;
    localparam logic [1:0] CUT_FUEL  = 2'd1;

    // Event type codes.
    localparam logic OP_SPARK = 1'b0;
    localparam logic OP_FUEL  = 1'b1;

    localparam int THRESH_SCALE = 100;

    localparam int SLOT_IDX_W = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;

    // Remainder unit: 32-bit dividend, 8-bit divisor, two quotient bits per cycle.
    localparam int DIV_W         = 32;
    localparam int REM_W         = 8;
    localparam int BITS_PER_STEP = 2;
    localparam int MOD_STEPS     = DIV_W / BITS_PER_STEP;
    localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

    typedef struct packed {
        logic              operation;
        logic signed [15:0] coolant_temp;
        logic [13:0]       pedal_position;
    } esp_in_t;

    typedef struct packed {
        logic skip;
        logic engaged;
        logic coolant_too_low;
        logic pedal_too_high;
    } esp_out_t;

    typedef struct packed {
        logic [7:0] offset;
        logic [7:0] adder;
        logic [7:0] period;
    } esp_slot_t;

    typedef struct packed {
        logic                            enable;
        logic                            coolant_en;
        logic                            pedal_en;
        logic [1:0]                      cut_sel;
        logic signed [15:0]              coolant_scaled;
        logic [13:0]                     pedal_scaled;
        esp_slot_t [PATTERN_SLOTS-1:0]   slots;
    } esp_cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
    } esp_mod_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [REM_W-1:0] remainder;
    } esp_mod_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOT,
        ST_WAIT,
        ST_DONE
    } esp_state_t;

    // One restoring step: shift one dividend bit into the partial remainder.
    function automatic logic [REM_W-1:0] esp_rem_step(
        input logic [REM_W-1:0] rem,
        input logic             bit_in,
        input logic [REM_W-1:0] divisor
    );
        logic [REM_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
        end
        return t[REM_W-1:0];
    endfunction

endpackage

FILE: sv/esp_cfg_regs.sv
module esp_cfg_regs
    import esp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output esp_cfg_t              cfg
);

    logic [4:0]                    mode_reg, mode_next;
    logic signed [15:0]            coolant_reg, coolant_next;
    logic [13:0]                   pedal_reg, pedal_next;
    esp_slot_t [PATTERN_SLOTS-1:0] slots_reg, slots_next;
    logic [8:0]                    coolant_raw;

    assign coolant_raw = cfg_wdata[8:0];

    // Thresholds are held already scaled to hundredths.
    always_comb begin
        mode_next    = mode_reg;
        coolant_next = coolant_reg;
        pedal_next   = pedal_reg;
        slots_next   = slots_reg;
        if (cfg_we) begin
            if (cfg_index == CFG_IDX_W'(CFG_MODE)) begin
                mode_next = cfg_wdata[4:0];
            end
            if (cfg_index == CFG_IDX_W'(CFG_COOLANT)) begin
                coolant_next = 16'({{7{coolant_raw[8]}}, coolant_raw} * 16'(THRESH_SCALE));
            end
            if (cfg_index == CFG_IDX_W'(CFG_PEDAL)) begin
                pedal_next = 14'(14'(cfg_wdata[6:0]) * 14'(THRESH_SCALE));
            end
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                if (cfg_index == CFG_IDX_W'(CFG_SLOT_BASE + i)) begin
                    slots_next[i] = cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            coolant_reg <= '0;
            pedal_reg   <= '0;
            slots_reg   <= '0;
        end else begin
            mode_reg    <= mode_next;
            coolant_reg <= coolant_next;
            pedal_reg   <= pedal_next;
            slots_reg   <= slots_next;
        end
    end

    assign cfg.enable         = mode_reg[0];
    assign cfg.coolant_en     = mode_reg[1];
    assign cfg.pedal_en       = mode_reg[2];
    assign cfg.cut_sel        = mode_reg[4:3];
    assign cfg.coolant_scaled = coolant_reg;
    assign cfg.pedal_scaled   = pedal_reg;
    assign cfg.slots          = slots_reg;

endmodule

FILE: sv/esp_mod_unit.sv
module esp_mod_unit
    import esp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  esp_mod_req_t req,
    output esp_mod_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     shift_reg, shift_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_W-1:0]     divisor_reg, divisor_next;
    logic [REM_W-1:0]     rem_mid;

    assign rem_mid = esp_rem_step(rem_reg, shift_reg[DIV_W-1], divisor_reg);

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            shift_next   = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next   = esp_rem_step(rem_mid, shift_reg[DIV_W-2], divisor_reg);
            shift_next = shift_reg << BITS_PER_STEP;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: sv/event_skip_pattern_gate_unit.sv
// When the cut does not engage, an accepted word goes from IDLE through DONE to m_valid; when it
// engages, the block visits SLOT and WAIT for each pattern slot with a nonzero period and SLOT
// alone for each zero slot. s_ready returns in the same cycle that the result is loaded, so
// a new word is taken only once the last one is through; the shared 2-bit-per-cycle remainder unit
// sets the pace, and a result held back by m_ready stalls the block until it is taken.
// aresetn is synchronous and active low; it clears both counters, the configuration and m_valid.
module event_skip_pattern_gate_unit
    import esp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  esp_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output esp_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    esp_cfg_t     cfg;
    esp_mod_req_t mod_req;
    esp_mod_rsp_t mod_rsp;

    esp_state_t            state_reg, state_next;
    logic [DIV_W-1:0]      spark_count_reg, spark_count_next;
    logic [DIV_W-1:0]      fuel_count_reg, fuel_count_next;
    logic [DIV_W-1:0]      count_reg, count_next;
    logic [SLOT_IDX_W-1:0] slot_idx_reg, slot_idx_next;
    logic                  skip_reg, skip_next;
    logic                  engaged_reg, engaged_next;
    logic                  too_low_reg, too_low_next;
    logic                  too_high_reg, too_high_next;
    logic                  m_valid_reg, m_valid_next;
    esp_out_t              m_data_reg, m_data_next;

    logic      accept;
    logic      covered;
    logic      active;
    logic      coolant_ok;
    logic      pedal_ok;
    logic      coolant_eng;
    esp_slot_t cur_slot;
    logic      last_slot;
    logic      fires;

    esp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    esp_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Gate decision on the incoming word.
    assign covered     = (s_data.operation == OP_SPARK) ? (cfg.cut_sel != CUT_FUEL)
                                                        : (cfg.cut_sel != CUT_SPARK);
    assign active      = covered && cfg.enable;
    assign coolant_ok  = s_data.coolant_temp > cfg.coolant_scaled;
    assign pedal_ok    = s_data.pedal_position <= cfg.pedal_scaled;
    assign coolant_eng = active && cfg.coolant_en && coolant_ok;

    assign cur_slot  = cfg.slots[slot_idx_reg];
    assign last_slot = (slot_idx_reg == SLOT_IDX_W'(PATTERN_SLOTS - 1));
    assign fires     = ({1'b0, mod_rsp.remainder} + {1'b0, cur_slot.adder})
                       >= {1'b0, cur_slot.period};

    always_comb begin
        state_next       = state_reg;
        spark_count_next = spark_count_reg;
        fuel_count_next  = fuel_count_reg;
        count_next       = count_reg;
        slot_idx_next    = slot_idx_reg;
        skip_next        = skip_reg;
        engaged_next     = engaged_reg;
        too_low_next     = too_low_reg;
        too_high_next    = too_high_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = count_reg + DIV_W'(cur_slot.offset);
        mod_req.divisor  = cur_slot.period;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == OP_SPARK) begin
                        count_next       = spark_count_reg;
                        spark_count_next = spark_count_reg + 1'b1;
                    end else begin
                        count_next      = fuel_count_reg;
                        fuel_count_next = fuel_count_reg + 1'b1;
                    end
                    engaged_next  = coolant_eng || (active && cfg.pedal_en && pedal_ok);
                    too_low_next  = active && cfg.coolant_en && !coolant_ok;
                    too_high_next = active && !coolant_eng && cfg.pedal_en && !pedal_ok;
                    skip_next     = 1'b0;
                    slot_idx_next = '0;
                    state_next    = (coolant_eng || (active && cfg.pedal_en && pedal_ok))
                                    ? ST_SLOT : ST_DONE;
                end
            end
            ST_SLOT: begin
                // A slot with zero period never fires and needs no division.
                if (cur_slot.period == '0) begin
                    if (last_slot) begin
                        state_next = ST_DONE;
                    end else begin
                        slot_idx_next = slot_idx_reg + 1'b1;
                    end
                end else begin
                    mod_req.start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mod_rsp.done) begin
                    skip_next = skip_reg || fires;
                    if (last_slot) begin
                        state_next = ST_DONE;
                    end else begin
                        slot_idx_next = slot_idx_reg + 1'b1;
                        state_next    = ST_SLOT;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.skip            = skip_reg;
                    m_data_next.engaged         = engaged_reg;
                    m_data_next.coolant_too_low = too_low_reg;
                    m_data_next.pedal_too_high  = too_high_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            spark_count_reg <= '0;
            fuel_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            spark_count_reg <= spark_count_next;
            fuel_count_reg  <= fuel_count_next;
            m_valid_reg     <= m_valid_next;
        end
        count_reg    <= count_next;
        slot_idx_reg <= slot_idx_next;
        skip_reg     <= skip_next;
        engaged_reg  <= engaged_next;
        too_low_reg  <= too_low_next;
        too_high_reg <= too_high_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A word can only be skipped when the cut engaged.
    a_skip_needs_engage: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.engaged || !m_data.skip))
        else $error("skip reported without engagement");

    // Pedal is not examined once coolant has engaged the cut.
    a_engage_excl_pedal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.engaged && m_data.pedal_too_high))
        else $error("engaged and pedal_too_high both set");

    // A spark word advances the spark counter by exactly one and leaves the fuel counter.
    a_spark_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.operation == OP_SPARK) |=>
            (spark_count_reg == $past(spark_count_reg) + 1'b1) && $stable(fuel_count_reg))
        else $error("spark counter did not advance correctly");

    // The remainder unit is never restarted while a division is in flight.
    a_mod_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_req.start |-> !mod_rsp.busy)
        else $error("remainder unit restarted while busy");

endmodule

FILE: tb/esp_gate_check.sv
`timescale 1ns / 1ps

module esp_gate_check
    import esp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  esp_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  esp_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    errors,
    output int                    n_pending,
    output int                    n_results,
    output int                    n_engaged,
    output int                    n_skipped
);

    localparam int MODE_EN      = 0;
    localparam int MODE_COOLANT = 1;
    localparam int MODE_PEDAL   = 2;

    logic [4:0]        mode_r;
    logic signed [8:0] thr_r;
    logic [6:0]        ped_r;
    logic [23:0]       slot_r [PATTERN_SLOTS];
    logic [31:0]       spark_cnt;
    logic [31:0]       fuel_cnt;
    esp_out_t          outcome_q [$];

    initial begin
        errors    = 0;
        n_pending = 0;
        n_results = 0;
        n_engaged = 0;
        n_skipped = 0;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("esp_gate_check: %s", msg);
        end
    endtask

    function automatic logic slot_hits(input logic [31:0] count, input logic [23:0] slot);
        logic [7:0]  period;
        logic [7:0]  adder;
        logic [31:0] sum;
        logic [31:0] rem;
        period = slot[7:0];
        adder  = slot[15:8];
        if (period == 8'd0) begin
            return 1'b0;
        end
        sum = count + {24'd0, slot[23:16]};
        rem = sum % {24'd0, period};
        return (rem + {24'd0, adder}) >= {24'd0, period};
    endfunction

    // Outcome of one event under the current settings, with the event's own
    // count taken before it advances.
    function automatic esp_out_t gate_outcome(input esp_in_t w, input logic [31:0] count);
        esp_out_t   r;
        logic [1:0] cut;
        logic       covered;
        r   = '0;
        cut = mode_r[4:3];
        covered = (w.operation == OP_SPARK) ? (cut != CUT_FUEL) : (cut != CUT_SPARK);
        if (covered && mode_r[MODE_EN]) begin
            if (mode_r[MODE_COOLANT]) begin
                if (int'($signed(w.coolant_temp)) > int'(thr_r) * THRESH_SCALE) begin
                    r.engaged = 1'b1;
                end else begin
                    r.coolant_too_low = 1'b1;
                end
            end
            if (!r.engaged && mode_r[MODE_PEDAL]) begin
                if (int'(w.pedal_position) <= int'(ped_r) * THRESH_SCALE) begin
                    r.engaged = 1'b1;
                end else begin
                    r.pedal_too_high = 1'b1;
                end
            end
            if (r.engaged) begin
                for (int i = 0; i < PATTERN_SLOTS; i++) begin
                    if (slot_hits(count, slot_r[i])) begin
                        r.skip = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_flag(input string name, input logic want, input logic got);
        if (got !== want) begin
            report($sformatf("%s of result %0d: expected %b, got %b",
                             name, n_results, want, got));
        end
    endtask

    always @(posedge aclk) begin : watch
        esp_out_t want;
        if (!aresetn) begin
            mode_r    <= '0;
            thr_r     <= '0;
            ped_r     <= '0;
            spark_cnt <= '0;
            fuel_cnt  <= '0;
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                slot_r[i] <= '0;
            end
            outcome_q.delete();
            n_pending <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MODE) begin
                    mode_r <= cfg_wdata[4:0];
                end else if (cfg_index == CFG_COOLANT) begin
                    thr_r <= cfg_wdata[8:0];
                end else if (cfg_index == CFG_PEDAL) begin
                    ped_r <= cfg_wdata[6:0];
                end else if (cfg_index >= CFG_SLOT_BASE &&
                             cfg_index < CFG_SLOT_BASE + PATTERN_SLOTS) begin
                    slot_r[cfg_index - CFG_SLOT_BASE] <= cfg_wdata;
                end
            end
            // Retire first so that a word leaving and one arriving on the same edge
            // never pair up with each other.
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    report("result word with no event outstanding");
                end else begin
                    want = outcome_q.pop_front();
                    check_flag("skip", want.skip, m_data.skip);
                    check_flag("engaged", want.engaged, m_data.engaged);
                    check_flag("coolant_too_low", want.coolant_too_low, m_data.coolant_too_low);
                    check_flag("pedal_too_high", want.pedal_too_high, m_data.pedal_too_high);
                end
                n_results++;
                if (m_data.engaged === 1'b1) begin
                    n_engaged++;
                end
                if (m_data.skip === 1'b1) begin
                    n_skipped++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.operation == OP_SPARK) begin
                    outcome_q.push_back(gate_outcome(s_data, spark_cnt));
                    spark_cnt <= spark_cnt + 32'd1;
                end else begin
                    outcome_q.push_back(gate_outcome(s_data, fuel_cnt));
                    fuel_cnt <= fuel_cnt + 32'd1;
                end
            end
            n_pending <= outcome_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import esp_pkg::*;

    localparam logic [1:0] CUT_BOTH  = 2'd2;
    localparam logic [1:0] CUT_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_EVENTS  = 140;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    esp_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    esp_out_t              m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int errors;
    int n_pending;
    int n_results;
    int n_engaged;
    int n_skipped;

    int sent     = 0;
    int settings = 0;
    int cycles   = 0;
    int rdy_hold = 0;
    bit steady   = 1'b0;
    int cur_thr  = 0;
    int cur_ped  = 0;

    always #2 aclk = ~aclk;

    event_skip_pattern_gate_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    esp_gate_check gate_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .n_pending (n_pending),
        .n_results (n_results),
        .n_engaged (n_engaged),
        .n_skipped (n_skipped)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (steady || !m_ready) begin
            m_ready  <= 1'b1;
            rdy_hold <= $urandom_range(0, 10);
        end else begin
            m_ready  <= 1'b0;
            rdy_hold <= pick_gap();
        end
    end

    function automatic esp_in_t ev(input logic op, input int temp, input int pedal);
        esp_in_t w;
        w.operation      = op;
        w.coolant_temp   = temp[15:0];
        w.pedal_position = pedal[13:0];
        return w;
    endfunction

    function automatic logic [23:0] mode_word(input logic en, input logic cool, input logic ped,
                                              input logic [1:0] cut, input logic [18:0] junk);
        return {junk, cut, ped, cool, en};
    endfunction

    function automatic logic [23:0] rand_slot();
        logic [7:0] period;
        logic [7:0] adder;
        int         r;
        r = $urandom_range(0, 19);
        if (r < 3) begin
            period = 8'd0;
        end else if (r < 5) begin
            period = 8'($urandom_range(0, 255));
        end else begin
            period = 8'($urandom_range(1, 12));
        end
        if ($urandom_range(0, 4) == 0) begin
            adder = 8'($urandom_range(0, 255));
        end else begin
            adder = 8'($urandom_range(0, 4));
        end
        return {8'($urandom_range(0, 255)), adder, period};
    endfunction

    task automatic put_reg(input int idx, input logic [23:0] d);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_wdata <= d;
    endtask

    task automatic close_regs();
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_event(input esp_in_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Lets every outstanding word come back, then idles for the number of cycles given by extra.
    task automatic drain(input int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_phase_regs(input int p);
        logic [23:0] d;
        int          t;
        steady = (p == 2);
        if (p == 0) begin
            // Every register at its all-ones extreme: cut mode 3, threshold -1,
            // every slot firing on every count.
            for (int i = 0; i < CFG_REGS; i++) begin
                put_reg(i, 24'hFFFFFF);
            end
            cur_thr = -1;
            cur_ped = 127;
        end else if (p == 1) begin
            put_reg(CFG_MODE, mode_word(1'b1, 1'b1, 1'b1, CUT_BOTH, '0));
            put_reg(CFG_COOLANT, 24'd0);
            put_reg(CFG_PEDAL, 24'd0);
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                put_reg(CFG_SLOT_BASE + i, 24'd0);
            end
            cur_thr = 0;
            cur_ped = 0;
        end else begin
            put_reg(CFG_MODE, mode_word($urandom_range(0, 9) != 0, 1'($urandom), 1'($urandom),
                                        2'($urandom), 19'($urandom)));
            if ($urandom_range(0, 3) == 0) begin
                t = $urandom_range(0, 511);
                cur_thr = (t >= 256) ? t - 512 : t;
            end else begin
                cur_thr = $urandom_range(0, 240) - 40;
            end
            d = 24'($urandom);
            d[8:0] = cur_thr[8:0];
            put_reg(CFG_COOLANT, d);
            cur_ped = $urandom_range(0, 127);
            d = 24'($urandom);
            d[6:0] = cur_ped[6:0];
            put_reg(CFG_PEDAL, d);
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                put_reg(CFG_SLOT_BASE + i, rand_slot());
            end
            if ($urandom_range(0, 2) == 0) begin
                put_reg(CFG_REGS + $urandom_range(0, 1), 24'($urandom));
            end
        end
        close_regs();
    endtask

    initial begin
        int temp;
        int pedal;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Settings straight out of reset leave the function disabled.
        send_event(ev(OP_SPARK, 32767, 0));
        send_event(ev(OP_FUEL, -32768, 16383));
        drain(4);

        // Both engage paths and their boundaries; slot 1 has a zero period.
        put_reg(CFG_MODE, mode_word(1'b1, 1'b1, 1'b1, CUT_BOTH, '0));
        put_reg(CFG_COOLANT, 24'd25);
        put_reg(CFG_PEDAL, 24'd20);
        put_reg(CFG_SLOT_BASE, {8'd0, 8'd1, 8'd3});
        put_reg(CFG_SLOT_BASE + 1, {8'd0, 8'd255, 8'd0});
        put_reg(CFG_SLOT_BASE + 2, {8'd5, 8'd0, 8'd7});
        close_regs();
        send_event(ev(OP_SPARK, 2501, 16383));
        send_event(ev(OP_SPARK, 2500, 2000));
        send_event(ev(OP_SPARK, 2500, 2001));
        send_event(ev(OP_FUEL, -32768, 0));
        send_event(ev(OP_FUEL, 32767, 16383));
        send_event(ev(OP_SPARK, -4000, 10000));
        send_event(ev(OP_FUEL, 20000, 0));
        send_event(ev(OP_FUEL, 2500, 2001));
        send_event(ev(OP_SPARK, 0, 0));
        drain(4);

        // Spark-only cut, pedal path only, junk above every register's width,
        // and a write to an index past the register map.
        put_reg(CFG_MODE, mode_word(1'b1, 1'b0, 1'b1, CUT_SPARK, 19'h7FFFF));
        put_reg(CFG_COOLANT, 24'hFFFF00);
        put_reg(CFG_PEDAL, 24'hFFFFFF);
        put_reg(CFG_SLOT_BASE, 24'hFFFFFF);
        put_reg(CFG_REGS, 24'h5A5A5A);
        close_regs();
        send_event(ev(OP_SPARK, 0, 12700));
        send_event(ev(OP_SPARK, 0, 12701));
        send_event(ev(OP_FUEL, 0, 0));
        drain(4);

        // Fuel-only cut on coolant at the top threshold.
        put_reg(CFG_MODE, mode_word(1'b1, 1'b1, 1'b0, CUT_FUEL, '0));
        put_reg(CFG_COOLANT, 24'd255);
        close_regs();
        send_event(ev(OP_FUEL, 25501, 16383));
        send_event(ev(OP_FUEL, 25500, 0));
        send_event(ev(OP_SPARK, 32767, 0));
        drain(4);

        // The unused cut code covers both events; bottom threshold.
        put_reg(CFG_MODE, mode_word(1'b1, 1'b1, 1'b0, CUT_SPARE, '0));
        put_reg(CFG_COOLANT, 24'h000100);
        close_regs();
        send_event(ev(OP_SPARK, -25600, 0));
        send_event(ev(OP_FUEL, -25599, 0));
        drain(4);

        // Both auto-engage bits set but the function itself off.
        put_reg(CFG_MODE, mode_word(1'b0, 1'b1, 1'b1, CUT_BOTH, '0));
        close_regs();
        send_event(ev(OP_SPARK, 32767, 0));
        send_event(ev(OP_FUEL, -32768, 16383));
        drain(4);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_phase_regs(p);
            for (int i = 0; i < PHASE_EVENTS; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: temp = cur_thr * THRESH_SCALE + $urandom_range(0, 600) - 300;
                    6, 7, 8:          temp = $urandom_range(0, 24000) - 4000;
                    default:          temp = $urandom_range(0, 65535);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: pedal = cur_ped * THRESH_SCALE + $urandom_range(0, 600) - 300;
                    6, 7, 8:          pedal = $urandom_range(0, 10000);
                    default:          pedal = $urandom_range(0, 16383);
                endcase
                if (pedal < 0) begin
                    pedal = 0;
                end else if (pedal > 16383) begin
                    pedal = 16383;
                end
                send_event(ev(1'($urandom), temp, pedal));
            end
            drain(4);
        end
        steady = 1'b0;
        drain(60);

        $display("Sent %0d events over %0d register settings; %0d result words checked.",
                 sent, settings, n_results);
        $display("The cut engaged on %0d events and skipped %0d of them.", n_engaged, n_skipped);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
